### src/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants for the sorted list table
// Holds request codes, result codes, sequencer states and the control
// structs passed between the sequencer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_PUT,
        S_SHRD,
        S_SHWR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    typedef struct packed {
        t_status status;
        logic    found;
    } t_result;

endpackage

`default_nettype wire

### src/slt_ram.sv
// ----------------------------------------------------------------------------
// slt_ram: entry storage of the sorted list table
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_ram #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                                       i_clk,
    input  wire slt_pkg::t_mem_ctl                    i_mem,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [slt_pkg::VALUE_W-1:0]                i_wdata,
    output logic [slt_pkg::VALUE_W-1:0]               o_rdata
);
    import slt_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_mem.rd_en) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### src/slt_ctrl.sv
// ----------------------------------------------------------------------------
// slt_ctrl: request sequencer of the sorted list table
// Walks the entry memory one read per step: shifts up for insert, scans
// for remove and lookup, shifts down after a remove hit.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_ctrl #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                                         i_clk,
    input  wire                                         i_rst_n,
    input  wire                                         i_valid,
    output logic                                        o_stall,
    input  wire slt_pkg::t_op                           i_operation,
    input  wire signed [slt_pkg::VALUE_W-1:0]           i_value,
    output slt_pkg::t_mem_ctl                           o_mem,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_raddr,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_waddr,
    output logic [slt_pkg::VALUE_W-1:0]                 o_wdata,
    input  wire [slt_pkg::VALUE_W-1:0]                  i_rdata,
    output logic                                        o_res_valid,
    input  wire                                         i_res_take,
    output slt_pkg::t_result                            o_res,
    output logic [$clog2(DEPTH+1)-1:0]                  o_count
);
    import slt_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_state                    r_state, n_state;
    t_op                       r_op, n_op;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic [CW-1:0]             r_idx, n_idx;
    logic [CW-1:0]             r_cnt, n_cnt;
    t_result                   r_res, n_res;

    logic [CW-1:0] w_idx_inc;
    logic [CW-1:0] w_idx_dec;
    logic [CW-1:0] w_raddr;
    logic          w_greater;
    logic          w_equal;
    logic          w_full;

    assign w_idx_inc = CW'(r_idx + 1'b1);
    assign w_idx_dec = CW'(r_idx - 1'b1);
    assign w_greater = $signed(i_rdata) > r_val;
    assign w_equal   = i_rdata == r_val;
    assign w_full    = r_cnt >= CW'(DEPTH);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_operation)
                        OP_INSERT: begin
                            if (w_full) begin
                                n_state = S_DONE;
                            end else if (r_cnt == '0) begin
                                n_state = S_PUT;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        OP_REMOVE, OP_LOOKUP: begin
                            n_state = (r_cnt == '0) ? S_DONE : S_RD;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                if (r_op == OP_INSERT) begin
                    if (w_greater) begin
                        n_state = (r_idx == CW'(1)) ? S_PUT : S_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (w_equal) begin
                    n_state = (r_op == OP_REMOVE) ? S_SHRD : S_DONE;
                end else if (w_idx_inc == r_cnt) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_PUT:  n_state = S_DONE;
            S_SHRD: n_state = (w_idx_inc >= r_cnt) ? S_DONE : S_SHWR;
            S_SHWR: n_state = S_SHRD;
            S_DONE: n_state = i_res_take ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_op  = r_op;
        n_val = r_val;
        n_idx = r_idx;
        n_cnt = r_cnt;
        n_res = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op         = i_operation;
                    n_val        = i_value;
                    n_res.status = ST_OK;
                    n_res.found  = 1'b0;
                    case (i_operation)
                        OP_INSERT: begin
                            n_idx = r_cnt;
                            if (w_full) begin
                                n_res.status = ST_FULL;
                            end
                        end
                        OP_REMOVE: begin
                            n_idx = '0;
                            if (r_cnt == '0) begin
                                n_res.status = ST_NOT_FOUND;
                            end
                        end
                        OP_CLEAR: n_cnt = '0;
                        default:  n_idx = '0;
                    endcase
                end
            end
            S_CMP: begin
                if (r_op == OP_INSERT) begin
                    if (w_greater) begin
                        n_idx = w_idx_dec;
                    end else begin
                        n_cnt = CW'(r_cnt + 1'b1);
                    end
                end else if (w_equal) begin
                    n_res.found = 1'b1;
                end else if (w_idx_inc == r_cnt) begin
                    if (r_op == OP_REMOVE) begin
                        n_res.status = ST_NOT_FOUND;
                    end
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            S_PUT: n_cnt = CW'(r_cnt + 1'b1);
            S_SHRD: begin
                if (w_idx_inc >= r_cnt) begin
                    n_cnt = CW'(r_cnt - 1'b1);
                end
            end
            S_SHWR: n_idx = w_idx_inc;
            default: ;
        endcase
    end

    // memory port and handshake outputs
    always_comb begin
        o_mem   = '0;
        w_raddr = r_idx;
        o_wdata = r_val;
        case (r_state)
            S_RD: begin
                o_mem.rd_en = 1'b1;
                w_raddr     = (r_op == OP_INSERT) ? w_idx_dec : r_idx;
            end
            S_CMP: begin
                if (r_op == OP_INSERT) begin
                    o_mem.wr_en = 1'b1;
                    o_wdata     = w_greater ? i_rdata : r_val;
                end
            end
            S_PUT: o_mem.wr_en = 1'b1;
            S_SHRD: begin
                o_mem.rd_en = w_idx_inc < r_cnt;
                w_raddr     = w_idx_inc;
            end
            S_SHWR: begin
                o_mem.wr_en = 1'b1;
                o_wdata     = i_rdata;
            end
            default: ;
        endcase
    end

    assign o_raddr     = w_raddr[AW-1:0];
    assign o_waddr     = r_idx[AW-1:0];
    assign o_stall     = r_state != S_IDLE;
    assign o_res_valid = r_state == S_DONE;
    assign o_res       = r_res;
    assign o_count     = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_val <= n_val;
        r_idx <= n_idx;
        r_res <= n_res;
    end

endmodule

`default_nettype wire

### src/sorted_list_table.sv
// ----------------------------------------------------------------------------
// sorted_list_table: ascending table of signed 32-bit values
// Insert, remove, clear and lookup on a bounded sorted table held in one
// synchronous memory; one result per request.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_operation, i_value
//   result    out        o_valid / i_stall    o_status, o_found,
//                                             o_entry_count, o_empty
//
// Requests are taken one at a time, and the single read port sets the pace.
// Clear, a full insert, and a remove or lookup on an empty table finish
// without a memory access. An insert reads and moves up each larger entry in
// turn; a remove or lookup reads the entries in order up to a hit or the end;
// a remove hit then moves each later entry down by one place.
// Reset: synchronous, active low; clears the entry count and handshake state.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_table #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire [1:0]                         i_operation,
    input  wire signed [slt_pkg::VALUE_W-1:0] i_value,
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic [1:0]                        o_status,
    output logic                              o_found,
    output logic [slt_pkg::COUNT_W-1:0]       o_entry_count,
    output logic                              o_empty
);
    import slt_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_mem_ctl           w_mem;
    logic [AW-1:0]      w_raddr;
    logic [AW-1:0]      w_waddr;
    logic [VALUE_W-1:0] w_wdata;
    logic [VALUE_W-1:0] w_rdata;
    logic               w_res_valid;
    logic               w_res_take;
    t_result            w_res;
    logic [CW-1:0]      w_count;

    // output register
    logic               r_out_valid;
    t_result            r_out_res;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_empty;

    // Request sequencer: scans and shifts the table entry by entry.
    slt_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (t_op'(i_operation)),
        .i_value     (i_value),
        .o_mem       (w_mem),
        .o_raddr     (w_raddr),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .i_rdata     (w_rdata),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res),
        .o_count     (w_count)
    );

    // Entry memory. The sequencer never reads and writes one entry in the
    // same cycle, so no forwarding is needed.
    slt_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_mem   (w_mem),
        .i_raddr (w_raddr),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // Load the result whenever the output register is free or draining.
    assign w_res_take = w_res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload holds while stalled; it changes only on a load.
    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out_res   <= w_res;
            r_out_count <= COUNT_W'(w_count);
            r_out_empty <= w_count == '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_res.status;
    assign o_found       = r_out_res.found;
    assign o_entry_count = r_out_count;
    assign o_empty       = r_out_empty;

`ifndef NO_ASSERTIONS
    // The entry count never runs past the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (w_count <= CW'(DEPTH)))
        else $error("entry count exceeds table depth");

    // A dropped insert is reported only with the table full.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res.status == ST_FULL) |-> (w_count == CW'(DEPTH)))
        else $error("full status with table not full");

    // A hit never comes with an error status.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res.found) |-> (w_res.status == ST_OK))
        else $error("found flag with error status");

    // An accepted request raises the stall and so blocks the next one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second request taken while one is in progress");
`endif

endmodule

`default_nettype wire
